/* hdl/rgb_box_blur_unit_macros.svh */
// Assertion helpers for the checker file.
`ifndef RGB_BOX_BLUR_UNIT_MACROS_SVH
`define RGB_BOX_BLUR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBB_CHK_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define RBB_CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

/* hdl/rbb_pkg.sv */
package rbb_pkg;

	localparam int PIX_W = 8;
	localparam int WR_DATA_W = 13;
	localparam int WR_INDEX_W = 2;

	localparam logic [WR_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [WR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [WR_INDEX_W-1:0] REG_WINDOW_SIZE = 2'd2;

	localparam logic [11:0] WIDTH_RESET = 12'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;
	localparam logic [3:0] WINDOW_RESET = 4'd3;
	localparam logic [12:0] MAX_HEIGHT = 13'd4096;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

/* hdl/rgb_box_blur_unit.sv */
// RGB box blur. Pixels enter in raster order; frame_start marks pixel (0,0).
// The last MAX_WINDOW-1 rows live in one line memory of (MAX_WINDOW-1)*MAX_WIDTH
// 24-bit words with a registered read. Each pixel is handled alone: the input
// transfer, window_size-1 line reads (one per cycle) followed by the arrival and
// addition of the last read data, a write-back, and, for an interior centre,
// the addition of window_size column sums, a bit-serial divide by window_size
// squared and the load of the output register. A pixel that yields no result
// returns to idle after its write-back; one that yields a result may also wait
// until the previous result in the output register is taken. A result waits in
// that output register, so the next pixel can start before it is taken.
// The line memory is not cleared after reset; windows read only rows written
// in the current frame.
module rgb_box_blur_unit #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_WINDOW = 15
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [rbb_pkg::WR_INDEX_W-1:0] wr_index,
	input  logic [rbb_pkg::WR_DATA_W-1:0] wr_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	input  logic frame_start,
	output logic out_valid,
	input  logic out_ready,
	output logic [10:0] out_col,
	output logic [11:0] out_row,
	output logic [7:0] blue_mean,
	output logic [7:0] green_mean,
	output logic [7:0] red_mean,
	output logic frame_last
);

	localparam int ROWS = MAX_WINDOW - 1;
	localparam int DEPTH = ROWS * MAX_WIDTH;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (CW > 12) ? CW : 12;
	localparam int SLW = $clog2(ROWS);
	localparam int WSW = $clog2(MAX_WINDOW + 1);
	localparam int XW = (WSW > 4) ? WSW : 4;
	localparam int IW = $clog2(MAX_WINDOW);
	localparam int CSW = rbb_pkg::PIX_W + $clog2(MAX_WINDOW);
	localparam int TSW = rbb_pkg::PIX_W + 2 * $clog2(MAX_WINDOW);
	localparam int DVW = 2 * WSW;
	localparam int DCW = $clog2(TSW + 1);
	localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
	localparam logic [SLW-1:0] LAST_SLOT = SLW'(ROWS - 1);

	rbb_pkg::state_t state_q, state_nx;

	logic [11:0] width_q;
	logic [12:0] height_q;
	logic [3:0] wsize_q;

	logic [CW-1:0] pos_c_q;
	logic [11:0] pos_r_q;
	logic [SLW-1:0] pos_s_q;
	logic [CW-1:0] cur_c_q;
	logic [11:0] cur_r_q;
	logic [SLW-1:0] cur_s_q;
	logic [23:0] pix_q;

	logic [23:0] mem [DEPTH];
	logic [23:0] rdata_q;
	logic rvalid_q;
	logic [SLW-1:0] rslot_q;
	logic [WSW-1:0] rcnt_q;

	logic [CSW-1:0] acc_q [3];
	logic [CSW-1:0] hist_q [3][MAX_WINDOW];
	logic [WSW-1:0] j_q;
	logic [TSW-1:0] tot_q [3];
	logic [DVW-1:0] rem_q [3];
	logic [DCW-1:0] dcnt_q;

	logic emit_q;
	logic [CW:0] cx_q;
	logic [12:0] cy_q;
	logic last_q;

	logic out_valid_q;
	logic [10:0] out_col_q;
	logic [11:0] out_row_q;
	logic [7:0] mean_q [3];
	logic last_out_q;

	// Clamped configuration.
	logic [CW-1:0] w_cl;
	logic [12:0] h_cl;
	logic [WSW-1:0] ws_cl, k_w, a_w;
	logic [EW-1:0] w_ext;
	logic [XW-1:0] ws_ext;

	always_comb begin
		w_ext = EW'(width_q);
		if (width_q == '0) begin
			w_cl = CW'(1);
		end else if (w_ext > EW'(MAX_WIDTH)) begin
			w_cl = CW'(MAX_WIDTH);
		end else begin
			w_cl = CW'(width_q);
		end
		if (height_q == '0) begin
			h_cl = 13'd1;
		end else if (height_q > rbb_pkg::MAX_HEIGHT) begin
			h_cl = rbb_pkg::MAX_HEIGHT;
		end else begin
			h_cl = height_q;
		end
		ws_ext = XW'(wsize_q);
		if (wsize_q == '0) begin
			ws_cl = WSW'(1);
		end else if (ws_ext > XW'(MAX_WINDOW)) begin
			ws_cl = WSW'(MAX_WINDOW);
		end else begin
			ws_cl = WSW'(wsize_q);
		end
		k_w = ws_cl >> 1;
		a_w = ws_cl - WSW'(1) - k_w;
	end

	// Position of an arriving pixel and the position that follows it.
	logic [CW-1:0] c0, c1, nc;
	logic [12:0] r0, r1, r2, nr;
	logic [SLW-1:0] s0, s1, s2, ns;

	always_comb begin
		c0 = frame_start ? '0 : pos_c_q;
		r0 = frame_start ? '0 : {1'b0, pos_r_q};
		s0 = frame_start ? '0 : pos_s_q;
		c1 = c0;
		r1 = r0;
		s1 = s0;
		if (c0 >= w_cl) begin
			c1 = '0;
			r1 = r0 + 13'd1;
			s1 = (s0 == LAST_SLOT) ? '0 : s0 + SLW'(1);
		end
		r2 = r1;
		s2 = s1;
		if (r1 >= h_cl) begin
			r2 = '0;
			s2 = '0;
		end
		nc = c1 + CW'(1);
		nr = r2;
		ns = s2;
		if ({1'b0, c1} + (CW + 1)'(1) >= {1'b0, w_cl}) begin
			nc = '0;
			if (r2 + 13'd1 >= h_cl) begin
				nr = '0;
				ns = '0;
			end else begin
				nr = r2 + 13'd1;
				ns = (s2 == LAST_SLOT) ? '0 : s2 + SLW'(1);
			end
		end
	end

	// Interior test for the centre whose bottom-right pixel is the current one.
	logic emit_c, last_c;
	logic [CW:0] cx_c;
	logic [12:0] cy_c;

	always_comb begin
		cx_c = {1'b0, cur_c_q} - (CW + 1)'(a_w);
		cy_c = {1'b0, cur_r_q} - 13'(a_w);
		emit_c = ({1'b0, cur_c_q} >= (CW + 1)'(ws_cl - WSW'(1)))
			&& ({1'b0, cur_r_q} >= 13'(ws_cl - WSW'(1)))
			&& (cx_c + (CW + 1)'(k_w) < {1'b0, w_cl})
			&& (cy_c + 13'(k_w) < h_cl);
		last_c = (cx_c + (CW + 1)'(k_w) + (CW + 1)'(1) == {1'b0, w_cl})
			&& (cy_c + 13'(k_w) + 13'd1 == h_cl);
	end

	// Control.
	logic accept, rd_issue, mem_we, load_out;
	logic [SLW-1:0] rslot_dec;
	logic [DVW-1:0] dv;

	assign accept = in_valid && in_ready;
	assign rslot_dec = (rslot_q == '0) ? LAST_SLOT : rslot_q - SLW'(1);
	assign dv = DVW'(ws_cl) * DVW'(ws_cl);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			rbb_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nx = rbb_pkg::ST_READ;
				end
			end
			rbb_pkg::ST_READ: begin
				if (rcnt_q == ws_cl - WSW'(1) && !rvalid_q) begin
					state_nx = rbb_pkg::ST_WRITE;
				end
			end
			rbb_pkg::ST_WRITE: begin
				state_nx = emit_c ? rbb_pkg::ST_SUM : rbb_pkg::ST_IDLE;
			end
			rbb_pkg::ST_SUM: begin
				if (j_q == ws_cl - WSW'(1)) begin
					state_nx = rbb_pkg::ST_DIV;
				end
			end
			rbb_pkg::ST_DIV: begin
				if (dcnt_q == DCW'(1)) begin
					state_nx = rbb_pkg::ST_DONE;
				end
			end
			rbb_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_nx = rbb_pkg::ST_IDLE;
				end
			end
			default: state_nx = rbb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_issue = 1'b0;
		mem_we = 1'b0;
		load_out = 1'b0;
		case (state_q)
			rbb_pkg::ST_IDLE: in_ready = 1'b1;
			rbb_pkg::ST_READ: rd_issue = (rcnt_q < ws_cl - WSW'(1));
			rbb_pkg::ST_WRITE: mem_we = 1'b1;
			rbb_pkg::ST_DONE: load_out = !out_valid_q || out_ready;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbb_pkg::ST_IDLE;
			width_q <= rbb_pkg::WIDTH_RESET;
			height_q <= rbb_pkg::HEIGHT_RESET;
			wsize_q <= rbb_pkg::WINDOW_RESET;
			pos_c_q <= '0;
			pos_r_q <= '0;
			pos_s_q <= '0;
			rvalid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (wr_en) begin
				case (wr_index)
					rbb_pkg::REG_IMAGE_WIDTH: width_q <= wr_data[11:0];
					rbb_pkg::REG_IMAGE_HEIGHT: height_q <= wr_data;
					rbb_pkg::REG_WINDOW_SIZE: wsize_q <= wr_data[3:0];
					default: width_q <= width_q;
				endcase
			end
			if (accept) begin
				pos_c_q <= nc;
				pos_r_q <= nr[11:0];
				pos_s_q <= ns;
			end
			rvalid_q <= rd_issue;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Line memory: read the rows above, then write this pixel back.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(cur_s_q) * ROW_STRIDE + AW'(cur_c_q)] <= pix_q;
		end
		if (rd_issue) begin
			rdata_q <= mem[AW'(rslot_dec) * ROW_STRIDE + AW'(cur_c_q)];
		end
	end

	// Datapath.
	logic [DVW:0] trial [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			trial[ch] = {rem_q[ch], tot_q[ch][TSW-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_c_q <= c1;
			cur_r_q <= r2[11:0];
			cur_s_q <= s2;
			rslot_q <= s2;
			rcnt_q <= '0;
			pix_q <= {red, green, blue};
			acc_q[0] <= CSW'(blue);
			acc_q[1] <= CSW'(green);
			acc_q[2] <= CSW'(red);
		end
		if (rd_issue) begin
			rslot_q <= rslot_dec;
			rcnt_q <= rcnt_q + WSW'(1);
		end
		if (rvalid_q) begin
			for (int ch = 0; ch < 3; ch++) begin
				acc_q[ch] <= acc_q[ch] + CSW'(rdata_q[8*ch +: 8]);
			end
		end
		if (mem_we) begin
			for (int ch = 0; ch < 3; ch++) begin
				for (int j = MAX_WINDOW - 1; j > 0; j--) begin
					hist_q[ch][j] <= hist_q[ch][j-1];
				end
				hist_q[ch][0] <= acc_q[ch];
				tot_q[ch] <= '0;
			end
			j_q <= '0;
			emit_q <= emit_c;
			cx_q <= cx_c;
			cy_q <= cy_c;
			last_q <= last_c;
		end
		if (state_q == rbb_pkg::ST_SUM) begin
			for (int ch = 0; ch < 3; ch++) begin
				tot_q[ch] <= tot_q[ch] + TSW'(hist_q[ch][j_q[IW-1:0]]);
				rem_q[ch] <= '0;
			end
			j_q <= j_q + WSW'(1);
			dcnt_q <= DCW'(TSW);
		end
		// Restoring divide, one quotient bit per cycle.
		if (state_q == rbb_pkg::ST_DIV) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (trial[ch] >= {1'b0, dv}) begin
					rem_q[ch] <= DVW'(trial[ch] - {1'b0, dv});
					tot_q[ch] <= {tot_q[ch][TSW-2:0], 1'b1};
				end else begin
					rem_q[ch] <= DVW'(trial[ch]);
					tot_q[ch] <= {tot_q[ch][TSW-2:0], 1'b0};
				end
			end
			dcnt_q <= dcnt_q - DCW'(1);
		end
		if (load_out && emit_q) begin
			out_col_q <= 11'(cx_q);
			out_row_q <= cy_q[11:0];
			last_out_q <= last_q;
			for (int ch = 0; ch < 3; ch++) begin
				mean_q[ch] <= tot_q[ch][7:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_col = out_col_q;
	assign out_row = out_row_q;
	assign blue_mean = mean_q[0];
	assign green_mean = mean_q[1];
	assign red_mean = mean_q[2];
	assign frame_last = last_out_q;

endmodule

/* hdl/rbb_checker.sv */
`include "rgb_box_blur_unit_macros.svh"

module rbb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [10:0] out_col,
	input logic [11:0] out_row
);

	// A held result stays until its transfer.
	`RBB_CHK_NEXT(out_hold, out_valid && !out_ready, out_valid)
	`RBB_CHK_NEXT(out_stable, out_valid && !out_ready, $stable(out_col) && $stable(out_row))
	// One pixel at a time: the unit is busy right after an input transfer.
	`RBB_CHK_NEXT(in_busy, in_valid && in_ready, !in_ready)
	// A new result only appears while a pixel is in work.
	`RBB_CHK_SAME(out_from_work, $rose(out_valid), !$past(in_ready))

endmodule

bind rgb_box_blur_unit rbb_checker u_rbb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_col(out_col),
	.out_row(out_row)
);

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

	localparam int LINE_ROWS = 14;
	localparam int LINE_LEN = 2048;
	localparam int WIN_MAX = 15;

	typedef struct packed {
		logic [10:0] col;
		logic [11:0] row;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic last;
	} blur_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [rbb_pkg::WR_INDEX_W-1:0] wr_index = '0;
	logic [rbb_pkg::WR_DATA_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] blue = '0, green = '0, red = '0;
	logic frame_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [10:0] out_col;
	logic [11:0] out_row;
	logic [7:0] blue_mean, green_mean, red_mean;
	logic frame_last;

	rgb_box_blur_unit u_top (.*);

	// Predictor state.
	logic [11:0] cfg_width = rbb_pkg::WIDTH_RESET;
	logic [12:0] cfg_height = rbb_pkg::HEIGHT_RESET;
	logic [3:0] cfg_window = rbb_pkg::WINDOW_RESET;
	logic [23:0] line_rows[LINE_ROWS][LINE_LEN];
	int col_sums[3][WIN_MAX];
	int cur_col = 0, cur_row = 0;

	blur_res_t expected_means[$];
	int errors = 0;
	int pixels_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	event start_hold;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("rgb_box_blur_unit regression: fail");
		$finish;
	end

	function automatic int clampi(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic void predict_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
			logic fs);
		int w, h, ws, k, a, c, rw, slot, s, cx, cy, sum;
		logic [23:0] v;
		blur_res_t res;
		w = clampi(cfg_width, 1, LINE_LEN);
		h = clampi(cfg_height, 1, 4096);
		ws = clampi(cfg_window, 1, WIN_MAX);
		k = ws / 2;
		a = ws - 1 - k;
		if (fs) begin
			cur_col = 0;
			cur_row = 0;
		end
		if (cur_col >= w) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= h)
			cur_row = 0;
		c = cur_col;
		rw = cur_row;
		for (int ch = 0; ch < 3; ch++)
			for (int j = WIN_MAX - 1; j > 0; j--)
				col_sums[ch][j] = col_sums[ch][j-1];
		col_sums[0][0] = b;
		col_sums[1][0] = g;
		col_sums[2][0] = r;
		slot = rw % LINE_ROWS;
		for (int i = 1; i < ws; i++) begin
			s = (slot + LINE_ROWS - (i % LINE_ROWS)) % LINE_ROWS;
			v = line_rows[s][c];
			// Entries never written only feed rows that cannot yield a result.
			if ($isunknown(v))
				v = '0;
			for (int ch = 0; ch < 3; ch++)
				col_sums[ch][0] += v[8*ch +: 8];
		end
		line_rows[slot][c] = {r, g, b};
		if (c >= ws - 1 && rw >= ws - 1) begin
			cx = c - a;
			cy = rw - a;
			if (cx + k < w && cy + k < h) begin
				for (int ch = 0; ch < 3; ch++) begin
					sum = 0;
					for (int j = 0; j < ws; j++)
						sum += col_sums[ch][j];
					sum = sum / (ws * ws);
					if (ch == 0) res.b = sum[7:0];
					else if (ch == 1) res.g = sum[7:0];
					else res.r = sum[7:0];
				end
				res.col = cx[10:0];
				res.row = cy[11:0];
				res.last = (cx + k + 1 == w && cy + k + 1 == h);
				expected_means.push_back(res);
			end
		end
		if (c + 1 >= w) begin
			cur_col = 0;
			cur_row = (rw + 1 >= h) ? 0 : rw + 1;
		end else begin
			cur_col = c + 1;
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		blue <= b;
		green <= g;
		red <= r;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		predict_pixel(b, g, r, fs);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_means.size() != 0)
			@(negedge clk);
		// A pixel without a result may still be in flight.
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(logic [rbb_pkg::WR_INDEX_W-1:0] idx,
			logic [rbb_pkg::WR_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			rbb_pkg::REG_IMAGE_WIDTH: cfg_width = data[11:0];
			rbb_pkg::REG_IMAGE_HEIGHT: cfg_height = data[12:0];
			rbb_pkg::REG_WINDOW_SIZE: cfg_window = data[3:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(int w, int h, int ws);
		drain();
		write_reg(rbb_pkg::REG_IMAGE_WIDTH, rbb_pkg::WR_DATA_W'(w));
		write_reg(rbb_pkg::REG_IMAGE_HEIGHT, rbb_pkg::WR_DATA_W'(h));
		write_reg(rbb_pkg::REG_WINDOW_SIZE, rbb_pkg::WR_DATA_W'(ws));
	endtask

	// Pattern 0 is random, 1 all ones, 2 all zeros, 3 alternating pixels of all ones and all zeros.
	task automatic send_frame(int count, int pattern);
		logic [7:0] b, g, r;
		for (int n = 0; n < count; n++) begin
			case (pattern)
				1: {b, g, r} = '1;
				2: {b, g, r} = '0;
				3: {b, g, r} = (n % 2) ? '1 : '0;
				default: {b, g, r} = 24'($urandom);
			endcase
			send_pixel(b, g, r, n == 0);
		end
	endtask

	task automatic test_window_extremes();
		set_geometry(4, 3, 3);
		send_frame(12, 1);
		set_geometry(3, 3, 3);
		send_frame(9, 2);
		set_geometry(15, 15, 15);
		send_frame(225, 1);
		set_geometry(16, 16, 15);
		send_frame(256, 3);
		set_geometry(5, 5, 4);
		send_frame(25, 0);
	endtask

	task automatic test_register_saturation();
		set_geometry(2, 2, 0);
		send_frame(4, 0);
		set_geometry(0, 3, 1);
		send_frame(3, 0);
		set_geometry(4095, 1, 1);
		send_frame(20, 0);
		set_geometry(1, 8191, 1);
		send_frame(10, 0);
		set_geometry(2, 0, 1);
		send_frame(4, 0);
	endtask

	task automatic test_output_backpressure();
		set_geometry(12, 10, 1);
		fork
			-> start_hold;
		join_none
		send_frame(120, 0);
	endtask

	task automatic test_random_frames();
		int w, h, ws, cnt, frame_idx;
		frame_idx = 0;
		while (pixels_sent < 1550) begin
			case (frame_idx % 5)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 50; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 50; end
				3: begin send_idle_pct = 23; recv_stall_pct = 23; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			ws = ($urandom_range(9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 15);
			w = $urandom_range(1, 24);
			h = $urandom_range(1, 20);
			cnt = w * h;
			// A few frames are cut short and the next one restarts the counters.
			if ($urandom_range(9) == 0)
				cnt = $urandom_range(1, cnt);
			set_geometry(w, h, ws);
			send_frame(cnt, 0);
			frame_idx++;
		end
	endtask

	always @(negedge clk)
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

	initial begin
		forever begin
			@(start_hold);
			hold_off = 1'b1;
			repeat (600) @(negedge clk);
			hold_off = 1'b0;
		end
	end

	always @(posedge clk) begin
		blur_res_t exp_res, got;
		if (arst_n && out_valid && out_ready) begin
			got = '{out_col, out_row, blue_mean, green_mean, red_mean, frame_last};
			if (expected_means.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, got);
				errors++;
			end else begin
				exp_res = expected_means.pop_front();
				if (got.col !== exp_res.col || got.row !== exp_res.row ||
						got.b !== exp_res.b || got.g !== exp_res.g ||
						got.r !== exp_res.r || got.last !== exp_res.last) begin
					$display("%0t: mismatch, expected %p, actual %p", $time, exp_res, got);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_window_extremes();
		test_register_saturation();
		test_output_backpressure();
		test_random_frames();
		in_valid <= 1'b0;
		while (expected_means.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("rgb_box_blur_unit regression: pass");
		else
			$display("rgb_box_blur_unit regression: fail");
		$finish;
	end

endmodule
